>>> sv/ate_pkg.sv
// ----------------------------------------------------------------------------
// ate_pkg
// Shared types and constants for the text terminal engine: command codes
// passed from the parser to the executor, queue entry layout, FSM states.
// ----------------------------------------------------------------------------
package ate_pkg;

    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int SEQ_LAST    = 15;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  COLS_RESET   = 8'd80;
    localparam logic [6:0]  ROWS_RESET   = 7'd25;
    localparam logic [7:0]  COLS_MAX     = 8'd128;
    localparam logic [6:0]  ROWS_MAX     = 7'd64;
    localparam logic [7:0]  DEFAULT_ATTR = 8'h07;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [15:0] BLANK_CELL   = {DEFAULT_ATTR, CHAR_SPACE};

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_ATTR = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_PRINT,
        CMD_NEWLINE,
        CMD_SETATTR,
        CMD_READ,
        CMD_RIGHT,
        CMD_LEFT,
        CMD_HOME,
        CMD_COL0,
        CMD_CLR_EOL,
        CMD_CLR_LINE,
        CMD_CLR_SCREEN,
        CMD_SGR
    } t_cmd_op;

    // d0/d1: character, attribute, or SGR keep mask and set bits
    typedef struct packed {
        t_cmd_op          op;
        logic [7:0]       d0;
        logic [7:0]       d1;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cmd;

    typedef struct packed {
        logic       we_cols;
        logic       we_rows;
        logic [7:0] cols;
        logic [6:0] rows;
    } t_cfg_wr;

    typedef enum logic [1:0] {
        PM_NORMAL,
        PM_ESC,
        PM_CSI
    } t_pmode;

    typedef enum logic [2:0] {
        BS_INIT,
        BS_IDLE,
        BS_READ,
        BS_SCR_RD,
        BS_SCR_WR,
        BS_FILL
    } t_bstate;

endpackage

>>> sv/ansi_text_terminal_engine.sv
// An item is queued in a register, executed from the queue, and its result registered out;
// a cell read first passes the read state. Throughput: one item per cycle through the parser
// while busy is low; a clear walks one cell per cycle, a scroll a read and a write state per
// copied cell plus one row fill. Reset: a pass blanks all 8192 cells; busy is high meanwhile.
// Results cannot be held off by the receiver; o_valid marks each one for a single cycle.
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine
// Character-cell terminal with ESC/CSI parsing, VGA attributes and scroll.
// ----------------------------------------------------------------------------
module ansi_text_terminal_engine
    import ate_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_char_byte,
    input  logic [7:0]  i_attr_value,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    output logic        o_valid,
    output logic [6:0]  o_cursor_col,
    output logic [5:0]  o_cursor_row,
    output logic [7:0]  o_current_attr,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd    f_cmd, q_cmd;
    t_cfg_wr cfg;
    logic    accept, q_full, q_empty, pop, init;
    logic    cfg_we;
    logic [7:0] cols;
    logic [6:0] rows;

    assign busy   = q_full | init;
    assign accept = start & ~busy;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;
    assign prdata = paddr[2] ? {25'd0, rows} : {24'd0, cols};

    // clamp size writes to the usable range
    always_comb begin
        cfg.we_cols = cfg_we & ~paddr[2];
        cfg.we_rows = cfg_we & paddr[2];
        cfg.cols    = pwdata[7:0];
        cfg.rows    = pwdata[6:0];
        if (cfg.cols == 8'd0) begin
            cfg.cols = 8'd1;
        end else if (cfg.cols > COLS_MAX) begin
            cfg.cols = COLS_MAX;
        end
        if (cfg.rows == 7'd0) begin
            cfg.rows = 7'd1;
        end else if (cfg.rows > ROWS_MAX) begin
            cfg.rows = ROWS_MAX;
        end
    end

    ate_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_char_byte  (i_char_byte),
        .i_attr_value (i_attr_value),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_cmd        (f_cmd)
    );

    ate_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ate_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (q_cmd),
        .i_cmd_valid    (~q_empty),
        .o_pop          (pop),
        .i_cfg          (cfg),
        .o_cols         (cols),
        .o_rows         (rows),
        .o_init         (init),
        .o_valid        (o_valid),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_current_attr (o_current_attr),
        .o_cell_char    (o_cell_char),
        .o_cell_attr    (o_cell_attr)
    );

endmodule

>>> sv/ate_front.sv
// ----------------------------------------------------------------------------
// ate_front
// Byte parser: decodes each item into one executor command, tracking the
// ESC / CSI sequence and folding SGR codes into a keep mask and set bits.
// ----------------------------------------------------------------------------
module ate_front
    import ate_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_char_byte,
    input  logic [7:0]  i_attr_value,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    output t_cmd        o_cmd
);

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_CC   = 8'h43;
    localparam logic [7:0] CH_CD   = 8'h44;
    localparam logic [7:0] CH_CG   = 8'h47;
    localparam logic [7:0] CH_CH   = 8'h48;
    localparam logic [7:0] CH_CJ   = 8'h4A;
    localparam logic [7:0] CH_CK   = 8'h4B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [9:0] V_SAT   = 10'd1000;

    // ANSI colour index to VGA order is a reversal of the three bits
    function automatic logic [3:0] cmap(input logic [2:0] idx, input logic bright);
        logic [3:0] v;
        v = {1'b0, idx[0], idx[1], idx[2]};
        if (bright && v != 4'd0) begin
            v = v | 4'h8;
        end
        return v;
    endfunction

    // returns {bright, keep, set} after one SGR code
    function automatic logic [16:0] sgr_apply(input logic [9:0] v, input logic br,
                                             input logic [7:0] k, input logic [7:0] s);
        logic       nb;
        logic [7:0] k2;
        logic [7:0] s2;
        logic [9:0] d;
        nb = br;
        k2 = 8'hFF;
        s2 = 8'h00;
        d  = 10'd0;
        if (v == 10'd0) begin
            k2 = 8'h00; s2 = DEFAULT_ATTR; nb = 1'b0;
        end else if (v == 10'd1) begin
            nb = 1'b1;
        end else if (v == 10'd22) begin
            nb = 1'b0;
        end else if (v == 10'd39) begin
            k2 = 8'hF0; s2 = DEFAULT_ATTR;
        end else if (v == 10'd49) begin
            k2 = 8'h0F;
        end else if (v >= 10'd30 && v <= 10'd37) begin
            d = v - 10'd30;
            k2 = 8'hF0; s2 = {4'h0, cmap(d[2:0], br)};
        end else if (v >= 10'd40 && v <= 10'd47) begin
            d = v - 10'd40;
            k2 = 8'h0F; s2 = {cmap(d[2:0], 1'b0), 4'h0};
        end else if (v >= 10'd90 && v <= 10'd97) begin
            d = v - 10'd90;
            k2 = 8'hF0; s2 = {4'h0, cmap(d[2:0], 1'b1)};
        end else if (v >= 10'd100 && v <= 10'd107) begin
            d = v - 10'd100;
            k2 = 8'h0F; s2 = {cmap(d[2:0], 1'b1), 4'h0};
        end
        return {nb, k & k2, (s & k2) | s2};
    endfunction

    t_pmode     r_mode, n_mode;
    logic [3:0] r_len, n_len;
    logic       r_is2, n_is2;
    logic [9:0] r_v, n_v;
    logic       r_dig, n_dig;
    logic       r_first, n_first;
    logic       r_br, n_br;
    logic [7:0] r_k, n_k;
    logic [7:0] r_s, n_s;

    logic        is_digit, is_letter, stored, print_it;
    logic [13:0] v_mul;
    logic [16:0] fld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= PM_NORMAL;
            r_len  <= 4'd0;
        end else begin
            r_mode <= n_mode;
            r_len  <= n_len;
        end
        r_is2   <= n_is2;
        r_v     <= n_v;
        r_dig   <= n_dig;
        r_first <= n_first;
        r_br    <= n_br;
        r_k     <= n_k;
        r_s     <= n_s;
    end

    assign is_digit  = i_char_byte >= CH_0 && i_char_byte <= CH_9;
    assign is_letter = (i_char_byte >= 8'h41 && i_char_byte <= 8'h5A)
                    || (i_char_byte >= 8'h61 && i_char_byte <= 8'h7A);
    assign stored    = r_len < 4'(SEQ_LAST);
    assign v_mul     = {1'b0, r_v, 3'b000} + {3'b000, r_v, 1'b0}
                     + {6'd0, i_char_byte - CH_0};
    assign fld       = sgr_apply(r_v, r_br, r_k, r_s);

    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_is2    = r_is2;
        n_v      = r_v;
        n_dig    = r_dig;
        n_first  = r_first;
        n_br     = r_br;
        n_k      = r_k;
        n_s      = r_s;
        print_it = 1'b0;
        o_cmd    = '{op: CMD_NOP, d0: 8'h00, d1: 8'h00, row: i_read_row, col: i_read_col};

        if (i_accept) begin
            unique case (i_operation)
                OP_ATTR: begin
                    o_cmd.op = CMD_SETATTR;
                    o_cmd.d0 = i_attr_value;
                end
                OP_READ: o_cmd.op = CMD_READ;
                OP_NONE: o_cmd.op = CMD_NOP;
                default: begin
                    unique case (r_mode)
                        PM_NORMAL: begin
                            if (i_char_byte == CH_ESC) begin
                                n_mode = PM_ESC;
                            end else begin
                                print_it = 1'b1;
                            end
                        end
                        PM_ESC: begin
                            if (i_char_byte == CH_LBR) begin
                                n_mode  = PM_CSI;
                                n_len   = 4'd0;
                                n_v     = 10'd0;
                                n_dig   = 1'b0;
                                n_first = 1'b1;
                                n_br    = 1'b0;
                                n_k     = 8'hFF;
                                n_s     = 8'h00;
                            end else begin
                                n_mode   = PM_NORMAL;
                                print_it = 1'b1;
                            end
                        end
                        default: begin
                            if (is_digit || is_letter || i_char_byte == CH_SEMI) begin
                                if (stored) begin
                                    n_len = r_len + 4'd1;
                                    if (r_len == 4'd0) begin
                                        n_is2 = i_char_byte == CH_2;
                                    end
                                    if (is_digit) begin
                                        n_v   = (v_mul > 14'(V_SAT)) ? V_SAT : v_mul[9:0];
                                        n_dig = 1'b1;
                                    end else if (i_char_byte == CH_SEMI) begin
                                        {n_br, n_k, n_s} = fld;
                                        n_v     = 10'd0;
                                        n_dig   = 1'b0;
                                        n_first = 1'b0;
                                    end
                                end
                                if (is_letter) begin
                                    n_mode = PM_NORMAL;
                                    n_len  = 4'd0;
                                    // a letter that finds the buffer full is dropped
                                    if (stored) begin
                                        if (r_len == 4'd0) begin
                                            unique case (i_char_byte)
                                                CH_CC:   o_cmd.op = CMD_RIGHT;
                                                CH_CD:   o_cmd.op = CMD_LEFT;
                                                CH_CH:   o_cmd.op = CMD_HOME;
                                                CH_CK:   o_cmd.op = CMD_CLR_EOL;
                                                CH_CG:   o_cmd.op = CMD_COL0;
                                                CH_M:    o_cmd.op = CMD_SGR;
                                                default: o_cmd.op = CMD_NOP;
                                            endcase
                                        end else if (r_len == 4'd1 && r_is2) begin
                                            if (i_char_byte == CH_CJ) begin
                                                o_cmd.op = CMD_CLR_SCREEN;
                                            end else if (i_char_byte == CH_CK) begin
                                                o_cmd.op = CMD_CLR_LINE;
                                            end
                                        end else if (i_char_byte == CH_M) begin
                                            o_cmd.op = CMD_SGR;
                                        end
                                        // an empty field before m only counts when first
                                        if (r_dig || r_first) begin
                                            o_cmd.d0 = fld[15:8];
                                            o_cmd.d1 = fld[7:0];
                                        end else begin
                                            o_cmd.d0 = r_k;
                                            o_cmd.d1 = r_s;
                                        end
                                    end
                                end
                            end else begin
                                n_mode   = PM_NORMAL;
                                print_it = 1'b1;
                            end
                        end
                    endcase
                end
            endcase
            if (print_it) begin
                o_cmd.op = (i_char_byte == CH_NL) ? CMD_NEWLINE : CMD_PRINT;
                o_cmd.d0 = i_char_byte;
            end
        end
    end

endmodule

>>> sv/ate_queue.sv
// ----------------------------------------------------------------------------
// ate_queue
// Short command queue between parser and executor.
// ----------------------------------------------------------------------------
module ate_queue
    import ate_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
`endif

endmodule

>>> sv/ate_back.sv
// ----------------------------------------------------------------------------
// ate_back
// Command executor: owns the cell store, cursor, attribute and size
// registers; walks the store for scroll, clears and the reset pass.
// ----------------------------------------------------------------------------
module ate_back
    import ate_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_pop,
    input  t_cfg_wr          i_cfg,
    output logic [7:0]       o_cols,
    output logic [6:0]       o_rows,
    output logic             o_init,
    output logic             o_valid,
    output logic [COL_W-1:0] o_cursor_col,
    output logic [ROW_W-1:0] o_cursor_row,
    output logic [7:0]       o_current_attr,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cell_attr
);

    logic [15:0] r_mem [2**ADDR_W];
    logic [15:0] r_rdata;

    t_bstate           r_state, n_state;
    logic [COL_W-1:0]  r_x, n_x;
    logic [ROW_W-1:0]  r_y, n_y;
    logic [7:0]        r_attr, n_attr;
    logic [7:0]        r_cols, n_cols;
    logic [6:0]        r_rows, n_rows;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row_end, n_row_end;
    logic [ADDR_W-1:0] r_init_addr, n_init_addr;
    logic              r_rd_ok, n_rd_ok;

    logic              r_o_valid;
    logic [COL_W-1:0]  r_o_col;
    logic [ROW_W-1:0]  r_o_row;
    logic [7:0]        r_o_attr, r_o_cc, r_o_ca;

    logic              fin;
    logic [7:0]        n_cc, n_ca;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    logic [7:0]        x_inc, col_inc;
    logic [6:0]        y_inc, row_inc, rows_m1;
    logic              new_line, line_scroll;

    assign x_inc   = {1'b0, r_x} + 8'd1;
    assign col_inc = {1'b0, r_col} + 8'd1;
    assign y_inc   = {1'b0, r_y} + 7'd1;
    assign row_inc = {1'b0, r_row} + 7'd1;
    assign rows_m1 = r_rows - 7'd1;
    assign line_scroll = y_inc >= r_rows;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_INIT;
            r_x         <= '0;
            r_y         <= '0;
            r_attr      <= DEFAULT_ATTR;
            r_cols      <= COLS_RESET;
            r_rows      <= ROWS_RESET;
            r_init_addr <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_y         <= n_y;
            r_attr      <= n_attr;
            r_cols      <= n_cols;
            r_rows      <= n_rows;
            r_init_addr <= n_init_addr;
            r_o_valid   <= fin;
        end
        r_row     <= n_row;
        r_col     <= n_col;
        r_row_end <= n_row_end;
        r_rd_ok   <= n_rd_ok;
        if (fin) begin
            r_o_col  <= n_x;
            r_o_row  <= n_y;
            r_o_attr <= n_attr;
            r_o_cc   <= n_cc;
            r_o_ca   <= n_ca;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_attr      = r_attr;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_row       = r_row;
        n_col       = r_col;
        n_row_end   = r_row_end;
        n_init_addr = r_init_addr;
        n_rd_ok     = r_rd_ok;
        fin         = 1'b0;
        n_cc        = 8'h00;
        n_ca        = 8'h00;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = {r_row, r_col};
        mem_wdata   = {r_attr, CHAR_SPACE};
        mem_raddr   = {i_cmd.row, i_cmd.col};
        new_line    = 1'b0;

        unique case (r_state)
            BS_INIT: begin
                mem_we      = 1'b1;
                mem_waddr   = r_init_addr;
                mem_wdata   = BLANK_CELL;
                n_init_addr = r_init_addr + 1'b1;
                if (&r_init_addr) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    fin   = 1'b1;
                    unique case (i_cmd.op)
                        CMD_PRINT: begin
                            mem_we    = 1'b1;
                            mem_waddr = {r_y, r_x};
                            mem_wdata = {r_attr, i_cmd.d0};
                            if (x_inc >= r_cols) begin
                                new_line = 1'b1;
                            end else begin
                                n_x = x_inc[COL_W-1:0];
                            end
                        end
                        CMD_NEWLINE:    new_line = 1'b1;
                        CMD_SETATTR:    n_attr = i_cmd.d0;
                        CMD_SGR:        n_attr = (r_attr & i_cmd.d0) | i_cmd.d1;
                        CMD_READ: begin
                            fin     = 1'b0;
                            n_rd_ok = ({1'b0, i_cmd.row} < r_rows)
                                   && ({1'b0, i_cmd.col} < r_cols);
                            n_state = BS_READ;
                        end
                        CMD_RIGHT: begin
                            if (x_inc < r_cols) begin
                                n_x = x_inc[COL_W-1:0];
                            end
                        end
                        CMD_LEFT: begin
                            if (r_x != '0) begin
                                n_x = r_x - 1'b1;
                            end
                        end
                        CMD_HOME: begin
                            n_x = '0;
                            n_y = '0;
                        end
                        CMD_COL0:       n_x = '0;
                        CMD_CLR_EOL: begin
                            fin       = 1'b0;
                            n_row     = r_y;
                            n_row_end = r_y;
                            n_col     = r_x;
                            n_state   = BS_FILL;
                        end
                        CMD_CLR_LINE: begin
                            fin       = 1'b0;
                            n_row     = r_y;
                            n_row_end = r_y;
                            n_col     = '0;
                            n_state   = BS_FILL;
                        end
                        CMD_CLR_SCREEN: begin
                            fin       = 1'b0;
                            n_row     = '0;
                            n_row_end = rows_m1[ROW_W-1:0];
                            n_col     = '0;
                            n_x       = '0;
                            n_y       = '0;
                            n_state   = BS_FILL;
                        end
                        default: ;
                    endcase
                    if (new_line) begin
                        n_x = '0;
                        if (line_scroll) begin
                            // last row: hold cursor there and scroll the store up
                            fin   = 1'b0;
                            n_y   = rows_m1[ROW_W-1:0];
                            n_col = '0;
                            if (r_rows == 7'd1) begin
                                n_row     = '0;
                                n_row_end = '0;
                                n_state   = BS_FILL;
                            end else begin
                                n_row   = '0;
                                n_state = BS_SCR_RD;
                            end
                        end else begin
                            n_y = y_inc[ROW_W-1:0];
                        end
                    end
                end
            end
            BS_READ: begin
                fin     = 1'b1;
                n_state = BS_IDLE;
                if (r_rd_ok) begin
                    n_cc = r_rdata[7:0];
                    n_ca = r_rdata[15:8];
                end
            end
            BS_SCR_RD: begin
                mem_raddr = {row_inc[ROW_W-1:0], r_col};
                n_state   = BS_SCR_WR;
            end
            BS_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_state   = BS_SCR_RD;
                if (col_inc == r_cols) begin
                    n_col = '0;
                    if (row_inc == rows_m1) begin
                        n_row     = rows_m1[ROW_W-1:0];
                        n_row_end = rows_m1[ROW_W-1:0];
                        n_state   = BS_FILL;
                    end else begin
                        n_row = row_inc[ROW_W-1:0];
                    end
                end else begin
                    n_col = col_inc[COL_W-1:0];
                end
            end
            BS_FILL: begin
                mem_we = 1'b1;
                if (col_inc == r_cols) begin
                    n_col = '0;
                    if (r_row == r_row_end) begin
                        fin     = 1'b1;
                        n_state = BS_IDLE;
                    end else begin
                        n_row = row_inc[ROW_W-1:0];
                    end
                end else begin
                    n_col = col_inc[COL_W-1:0];
                end
            end
            default: n_state = BS_IDLE;
        endcase

        // size writes must arrive only while idle, which the block does not enforce; clamp the cursor into the new area
        if (i_cfg.we_cols) begin
            n_cols = i_cfg.cols;
            if ({1'b0, r_x} >= i_cfg.cols) begin
                n_x = 7'(i_cfg.cols - 8'd1);
            end
        end
        if (i_cfg.we_rows) begin
            n_rows = i_cfg.rows;
            if ({1'b0, r_y} >= i_cfg.rows) begin
                n_y = 6'(i_cfg.rows - 7'd1);
            end
        end
    end

    assign o_cols         = r_cols;
    assign o_rows         = r_rows;
    assign o_init         = r_state == BS_INIT;
    assign o_valid        = r_o_valid;
    assign o_cursor_col   = r_o_col;
    assign o_cursor_row   = r_o_row;
    assign o_current_attr = r_o_attr;
    assign o_cell_char    = r_o_cc;
    assign o_cell_attr    = r_o_ca;

`ifndef ASSERT_OFF
    a_col_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_x} < r_cols)
        else $error("cursor column outside area");
    a_row_in_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_y} < r_rows)
        else $error("cursor row outside area");
    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BS_SCR_WR |-> $past(r_state) == BS_SCR_RD)
        else $error("scroll write without preceding read");
`endif

endmodule

>>> tb/sv/term_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// term_checker
// Watches the item, result and register channels of the text terminal
// engine, keeps its own copy of the screen, cursor, attribute and escape
// parser, and compares every result against the oldest expected one.
// ----------------------------------------------------------------------------
module term_checker
    import ate_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_char_byte,
    input  logic [7:0]  i_attr_value,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    input  logic        o_valid,
    input  logic [6:0]  o_cursor_col,
    input  logic [5:0]  o_cursor_row,
    input  logic [7:0]  o_current_attr,
    input  logic [7:0]  o_cell_char,
    input  logic [7:0]  o_cell_attr,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [7:0] ESC_CHAR   = 8'h1B;
    localparam logic [7:0] LF_CHAR    = 8'h0A;
    localparam logic [2:0] ADDR_COLS  = 3'd0;
    localparam logic [2:0] ADDR_ROWS  = 3'd4;
    localparam int         STRIDE     = 128;
    localparam int         BUF_LAST   = 15;

    typedef struct {
        logic [6:0] col;
        logic [5:0] row;
        logic [7:0] attr;
        logic [7:0] ch;
        logic [7:0] cattr;
    } t_term_view;

    logic [15:0] screen [0:8191];
    int          cur_x, cur_y, n_cols, n_rows, esc_len;
    logic [7:0]  pen_attr;
    t_pmode      esc_mode;
    logic [7:0]  esc_buf [0:15];
    t_term_view  expected_q [$];
    int          errors = 0;

    function automatic void put_cell(int x, int y, logic [7:0] ch, logic [7:0] at);
        if (x < STRIDE && y < 64) screen[y * STRIDE + x] = {at, ch};
    endfunction

    function automatic void blank_span(int y, int x0, int x1);
        for (int x = x0; x < x1; x++) put_cell(x, y, CHAR_SPACE, pen_attr);
    endfunction

    function automatic void scroll_screen();
        for (int y = 0; y + 1 < n_rows; y++)
            for (int x = 0; x < n_cols; x++)
                screen[y * STRIDE + x] = screen[(y + 1) * STRIDE + x];
        blank_span(n_rows - 1, 0, n_cols);
    endfunction

    function automatic void fix_row();
        if (cur_y >= n_rows) begin
            cur_y = n_rows - 1;
            scroll_screen();
        end
    endfunction

    function automatic void print_char(logic [7:0] c);
        if (c == LF_CHAR) begin
            cur_x = 0;
            cur_y++;
        end else begin
            fix_row();
            if (cur_x >= n_cols) begin
                cur_x = 0;
                cur_y++;
                fix_row();
            end
            put_cell(cur_x, cur_y, c, pen_attr);
            cur_x++;
            if (cur_x >= n_cols) begin
                cur_x = 0;
                cur_y++;
            end
        end
        fix_row();
    endfunction

    function automatic logic [3:0] vga_colour(int idx, bit bright);
        logic [3:0] v;
        case (idx & 7)
            0: v = 4'h0;
            1: v = 4'h4;
            2: v = 4'h2;
            3: v = 4'h6;
            4: v = 4'h1;
            5: v = 4'h5;
            6: v = 4'h3;
            default: v = 4'h7;
        endcase
        if (bright && v != 0) v |= 4'h8;
        return v;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void apply_sgr();
        int pos;
        int v;
        bit bright;
        pos = 0;
        bright = 0;
        if (esc_len == 1 && esc_buf[0] == "m") begin
            pen_attr = DEFAULT_ATTR;
            return;
        end
        for (int g = 0; g <= 16 && pos < esc_len; g++) begin
            v = 0;
            while (pos < esc_len && is_digit(esc_buf[pos])) begin
                v = v * 10 + int'(esc_buf[pos] - "0");
                if (v > 1000) v = 1000;
                pos++;
            end
            if (v == 0) begin
                pen_attr = DEFAULT_ATTR;
                bright = 0;
            end else if (v == 1) bright = 1;
            else if (v == 22) bright = 0;
            else if (v == 39) pen_attr = {pen_attr[7:4], 4'h7};
            else if (v == 49) pen_attr = {4'h0, pen_attr[3:0]};
            else if (v >= 30 && v <= 37) pen_attr = {pen_attr[7:4], vga_colour(v - 30, bright)};
            else if (v >= 40 && v <= 47) pen_attr = {vga_colour(v - 40, 0), pen_attr[3:0]};
            else if (v >= 90 && v <= 97) pen_attr = {pen_attr[7:4], vga_colour(v - 90, 1)};
            else if (v >= 100 && v <= 107) pen_attr = {vga_colour(v - 100, 1), pen_attr[3:0]};
            if (pos < esc_len && esc_buf[pos] == ";") pos++;
            if (pos < esc_len && esc_buf[pos] == "m") break;
        end
    endfunction

    function automatic void run_csi();
        if (esc_len == 1) begin
            case (esc_buf[0])
                "C": if (cur_x + 1 < n_cols) cur_x++;
                "D": if (cur_x > 0) cur_x--;
                "H": begin
                    cur_x = 0;
                    cur_y = 0;
                end
                "K": blank_span(cur_y, cur_x, n_cols);
                "G": cur_x = 0;
                "m": apply_sgr();
                default: ;
            endcase
        end else if (esc_len == 2) begin
            if (esc_buf[0] == "2") begin
                if (esc_buf[1] == "J") begin
                    for (int y = 0; y < n_rows; y++) blank_span(y, 0, n_cols);
                    cur_x = 0;
                    cur_y = 0;
                end else if (esc_buf[1] == "K") begin
                    blank_span(cur_y, 0, n_cols);
                end
            end else if (esc_buf[1] == "m") begin
                apply_sgr();
            end
        end else if (esc_len > 2 && esc_buf[(esc_len - 1) & BUF_LAST] == "m") begin
            apply_sgr();
        end
        esc_mode = PM_NORMAL;
        esc_len = 0;
    endfunction

    function automatic void feed_byte(logic [7:0] c);
        bit letter;
        letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        if (esc_mode == PM_NORMAL) begin
            if (c == ESC_CHAR) begin
                esc_mode = PM_ESC;
                esc_len = 0;
                return;
            end
        end else if (esc_mode == PM_ESC) begin
            if (c == "[") begin
                esc_mode = PM_CSI;
                esc_len = 0;
                return;
            end
            esc_mode = PM_NORMAL;
            esc_len = 0;
        end else begin
            if (is_digit(c) || c == ";" || letter) begin
                // drop bytes once the buffer is full
                if (esc_len < BUF_LAST) begin
                    esc_buf[esc_len] = c;
                    esc_len++;
                end
                if (letter) run_csi();
                return;
            end
            esc_mode = PM_NORMAL;
            esc_len = 0;
        end
        print_char(c);
    endfunction

    function automatic t_term_view terminal_step(logic [1:0] op, logic [7:0] ch,
                                                 logic [7:0] av, int r, int c);
        t_term_view t;
        t.ch = 8'h00;
        t.cattr = 8'h00;
        if (op == OP_PUT) feed_byte(ch);
        else if (op == OP_ATTR) pen_attr = av;
        else if (op == OP_READ && r < n_rows && c < n_cols) begin
            t.ch = screen[r * STRIDE + c][7:0];
            t.cattr = screen[r * STRIDE + c][15:8];
        end
        t.col = cur_x[6:0];
        t.row = cur_y[5:0];
        t.attr = pen_attr;
        return t;
    endfunction

    function automatic void clamp_cursor();
        if (cur_x >= n_cols) cur_x = n_cols - 1;
        if (cur_y >= n_rows) cur_y = n_rows - 1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_term_view want;
        int v;
        if (!i_rst_n) begin
            for (int i = 0; i < 8192; i++) screen[i] = BLANK_CELL;
            cur_x = 0;
            cur_y = 0;
            pen_attr = DEFAULT_ATTR;
            esc_mode = PM_NORMAL;
            esc_len = 0;
            n_cols = 80;
            n_rows = 25;
            expected_q.delete();
        end else begin
            if (o_valid) begin
                if (expected_q.size() == 0) begin
                    $display("[%0t] result with no item outstanding", $realtime);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_cursor_col !== want.col) report_mismatch("cursor_col", o_cursor_col, want.col);
                    if (o_cursor_row !== want.row) report_mismatch("cursor_row", o_cursor_row, want.row);
                    if (o_current_attr !== want.attr)
                        report_mismatch("current_attr", o_current_attr, want.attr);
                    if (o_cell_char !== want.ch) report_mismatch("cell_char", o_cell_char, want.ch);
                    if (o_cell_attr !== want.cattr)
                        report_mismatch("cell_attr", o_cell_attr, want.cattr);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_COLS) begin
                    v = pwdata[7:0];
                    n_cols = (v == 0) ? 1 : (v > 128) ? 128 : v;
                    clamp_cursor();
                end else if (paddr == ADDR_ROWS) begin
                    v = pwdata[6:0];
                    n_rows = (v == 0) ? 1 : (v > 64) ? 64 : v;
                    clamp_cursor();
                end
            end
            if (start && !busy)
                expected_q.push_back(terminal_step(i_operation, i_char_byte, i_attr_value,
                                                   i_read_row, i_read_col));
        end
        o_pending <= expected_q.size();
    end

    assign o_errors = errors;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the text terminal engine with printed bytes, escape sequences,
// attribute writes and cell reads over a series of screen sizes, in bursts
// with random gaps or in steady runs; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import ate_pkg::*;

    localparam logic [7:0] ESC_CHAR  = 8'h1B;
    localparam logic [7:0] LF_CHAR   = 8'h0A;
    localparam logic [2:0] ADDR_COLS = 3'd0;
    localparam logic [2:0] ADDR_ROWS = 3'd4;
    localparam int         CYCLE_LIMIT = 20000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = OP_NONE;
    logic [7:0]  i_char_byte = 8'h00;
    logic [7:0]  i_attr_value = 8'h00;
    logic [5:0]  i_read_row = 6'd0;
    logic [6:0]  i_read_col = 7'd0;
    logic        o_valid;
    logic [6:0]  o_cursor_col;
    logic [5:0]  o_cursor_row;
    logic [7:0]  o_current_attr;
    logic [7:0]  o_cell_char;
    logic [7:0]  o_cell_attr;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;

    int cycle_count = 0;
    int area_cols = 80, area_rows = 25;
    int items_sent, burst_left;
    bit steady;

    always #5 i_clk = ~i_clk;

    ansi_text_terminal_engine dut (.*);

    term_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_operation, .i_char_byte, .i_attr_value,
        .i_read_row, .i_read_col, .o_valid, .o_cursor_col, .o_cursor_row,
        .o_current_attr, .o_cell_char, .o_cell_attr, .psel, .penable, .pwrite,
        .paddr, .pwdata, .pready, .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] ch, logic [7:0] av,
                             logic [5:0] r, logic [6:0] c);
        start <= 1'b1;
        i_operation <= op;
        i_char_byte <= ch;
        i_attr_value <= av;
        i_read_row <= r;
        i_read_col <= c;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (!steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic send_byte(logic [7:0] ch);
        send_item(OP_PUT, ch, 8'($urandom), 6'($urandom), 7'($urandom));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_read(bit in_area);
        if (in_area)
            send_item(OP_READ, 8'($urandom), 8'($urandom),
                      6'($urandom_range(0, area_rows - 1)),
                      7'($urandom_range(0, area_cols - 1)));
        else
            send_item(OP_READ, 8'($urandom), 8'($urandom), 6'($urandom), 7'($urandom));
    endtask

    // hold off until the block is idle with nothing outstanding
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_area(int cols, int rows);
        drain();
        write_reg(ADDR_COLS, cols);
        write_reg(ADDR_ROWS, rows);
        cols &= 8'hFF;
        rows &= 7'h7F;
        area_cols = (cols == 0) ? 1 : (cols > 128) ? 128 : cols;
        area_rows = (rows == 0) ? 1 : (rows > 64) ? 64 : rows;
    endtask

    function automatic string sgr_number();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return "0";
            1: return "1";
            2: return "22";
            3: return $sformatf("%0d", $urandom_range(30, 39));
            4: return $sformatf("%0d", $urandom_range(40, 49));
            5: return $sformatf("%0d", $urandom_range(90, 97));
            6: return $sformatf("%0d", $urandom_range(100, 107));
            7: return $sformatf("%0d", $urandom_range(0, 99999));
            default: return $sformatf("%0d", $urandom_range(0, 120));
        endcase
    endfunction

    task automatic send_csi();
        string body, cmds;
        int k, n;
        cmds = "CDHKGmJ";
        body = "";
        k = $urandom_range(0, 9);
        if (k == 0) begin
            n = $urandom_range(0, 2);
            body = (n == 0) ? "2J" : (n == 1) ? "2K" : "2m";
        end else if (k == 1) begin
            // a long field that can overfill the buffer so the final letter is lost
            n = $urandom_range(12, 18);
            for (int i = 0; i < n; i++) body = {body, string'(8'("0" + $urandom_range(0, 9)))};
            body = {body, ($urandom_range(0, 1) ? ";m" : "m")};
        end else if (k <= 3) begin
            body = string'(cmds[$urandom_range(0, cmds.len() - 1)]);
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (i != 0) body = {body, ";"};
                body = {body, sgr_number()};
            end
            if ($urandom_range(0, 4) == 0)
                body = {body, string'(8'($urandom_range(0, 1) ? "A" + $urandom_range(0, 25)
                                                                : "a" + $urandom_range(0, 25)))};
            else
                body = {body, "m"};
        end
        send_byte(ESC_CHAR);
        send_byte("[");
        send_text(body);
    endtask

    task automatic random_phase(int quota);
        int r;
        items_sent = 0;
        while (items_sent < quota) begin
            r = $urandom_range(0, 99);
            if (r < 50) send_csi();
            else if (r < 58) send_byte(LF_CHAR);
            else if (r < 70) send_byte(8'($urandom));
            else if (r < 77)
                send_item(OP_ATTR, 8'($urandom), 8'($urandom), 6'($urandom), 7'($urandom));
            else if (r < 91) send_read($urandom_range(0, 2) != 0);
            else if (r < 94)
                send_item(OP_NONE, 8'($urandom), 8'($urandom), 6'($urandom), 7'($urandom));
            else begin
                // broken sequences
                send_byte(ESC_CHAR);
                if ($urandom_range(0, 1)) send_byte(8'($urandom));
                else begin
                    send_byte("[");
                    send_text(sgr_number());
                    send_byte($urandom_range(0, 1) ? 8'h21 : ESC_CHAR);
                end
            end
        end
    endtask

    initial begin
        steady = 1'b0;
        burst_left = 8;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy);

        // directed part at the reset size
        send_item(OP_ATTR, 8'h00, 8'hFF, 6'd0, 7'd0);
        send_byte(8'hFF);
        send_item(OP_ATTR, 8'hFF, 8'h00, 6'h3F, 7'h7F);
        send_byte(8'h00);
        send_item(OP_READ, 8'h00, 8'h00, 6'd0, 7'd0);
        send_item(OP_READ, 8'hFF, 8'hFF, 6'h3F, 7'h7F);
        send_item(OP_NONE, 8'hFF, 8'hFF, 6'h3F, 7'h7F);
        send_text(string'({ESC_CHAR, "x", ESC_CHAR, ESC_CHAR}));
        send_text(string'({ESC_CHAR, "[!", ESC_CHAR, "[1;30m"}));
        send_text(string'({ESC_CHAR, "[2J"}));
        send_byte(LF_CHAR);

        set_area(0, 0);
        random_phase(40);
        set_area(255, 127);
        random_phase(20);
        set_area(128, 64);
        steady = 1'b1;
        random_phase(15);
        for (int p = 0; p < 9; p++) begin
            set_area($urandom_range(1, 20), $urandom_range(1, 10));
            steady = (p % 3 == 1);
            random_phase(95);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
